FILE: src/ddgo_pkg.sv
// Shared constants, types and tables for the gyro-aided odometry block.
package ddgo_pkg;

	// Reset value of the wheel scale register, metres per tick scaled by 2^32.
	localparam logic [23:0] MptReset = 24'd366325;

	// Encoder wrap detection window.
	localparam logic [15:0] WrapHi = 16'd60000;
	localparam logic [15:0] WrapLo = 16'd5000;

	// Angles in hundredths of a degree.
	localparam logic signed [16:0] HalfTurn    = 17'sd18000;
	localparam logic signed [16:0] FullTurn    = 17'sd36000;
	localparam logic signed [15:0] QuarterTurn = 16'sd9000;
	localparam logic signed [15:0] HalfTurn16  = 16'sd18000;

	// Rotator settings: iteration count and start vector length in Q30.
	localparam int unsigned CordicSteps = 16;
	localparam logic signed [32:0] CordicGainQ30 = 33'sd652032874;

	// Arctangent of 2^-i in hundredths of a degree scaled by 2^16.
	function automatic logic signed [31:0] atan_q16(input logic [3:0] idx);
		logic signed [31:0] r;
		case (idx)
			4'd0:    r = 32'sd294912000;
			4'd1:    r = 32'sd174096719;
			4'd2:    r = 32'sd91987925;
			4'd3:    r = 32'sd46694507;
			4'd4:    r = 32'sd23437864;
			4'd5:    r = 32'sd11730358;
			4'd6:    r = 32'sd5866610;
			4'd7:    r = 32'sd2933484;
			4'd8:    r = 32'sd1466765;
			4'd9:    r = 32'sd733385;
			4'd10:   r = 32'sd366693;
			4'd11:   r = 32'sd183346;
			4'd12:   r = 32'sd91673;
			4'd13:   r = 32'sd45837;
			4'd14:   r = 32'sd22918;
			4'd15:   r = 32'sd11459;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Rotator sequencer states.
	typedef enum logic [2:0] {
		C_IDLE,
		C_ROT,
		C_FIX,
		C_RND,
		C_DONE
	} ddgo_cstate_t;

	// Main sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_CSTART,
		S_CWAIT,
		S_MUL_P,
		S_MUL_LO,
		S_MUL_HI,
		S_ROUND,
		S_ACC,
		S_DONE
	} ddgo_state_t;

	// Request to the rotator.
	typedef struct packed {
		logic               start;
		logic signed [15:0] angle;
	} ddgo_cordic_req_t;

	// Answer from the rotator.
	typedef struct packed {
		logic               done;
		logic signed [15:0] cos_q15;
		logic signed [15:0] sin_q15;
	} ddgo_cordic_rsp_t;

endpackage

FILE: src/ddgo_cordic.sv
// Iterative rotator giving cosine and sine of a heading in Q1.15.
module ddgo_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ddgo_pkg::ddgo_cordic_req_t req,
	output ddgo_pkg::ddgo_cordic_rsp_t rsp
);

	ddgo_pkg::ddgo_cstate_t state_q, state_d;
	logic signed [32:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [3:0]         i_q;
	logic               neg_q;
	logic signed [15:0] cos_q, sin_q;

	logic signed [15:0] fold;
	logic               fold_neg;
	logic signed [32:0] dx, dy;
	logic signed [31:0] atan_i;

	// Round a Q30 value half up to Q15 and saturate to 16 bits.
	function automatic logic signed [15:0] q30_to_q15(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [33:0] r;
		t = 34'(v) + 34'sd16384;
		r = t >>> 15;
		if (r > 34'sd32767) begin
			return 16'sh7FFF;
		end else if (r < -34'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	// Fold headings beyond a quarter turn back by a half turn.
	always_comb begin
		fold     = req.angle;
		fold_neg = 1'b0;
		if (req.angle > ddgo_pkg::QuarterTurn) begin
			fold     = req.angle - ddgo_pkg::HalfTurn16;
			fold_neg = 1'b1;
		end else if (req.angle < -ddgo_pkg::QuarterTurn) begin
			fold     = req.angle + ddgo_pkg::HalfTurn16;
			fold_neg = 1'b1;
		end
	end

	// Shifted terms of the current micro-rotation.
	assign dx     = y_q >>> i_q;
	assign dy     = x_q >>> i_q;
	assign atan_i = ddgo_pkg::atan_q16(i_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ddgo_pkg::C_IDLE: begin
				if (req.start) begin
					state_d = ddgo_pkg::C_ROT;
				end
			end
			ddgo_pkg::C_ROT: begin
				if (i_q == 4'(ddgo_pkg::CordicSteps - 1)) begin
					state_d = ddgo_pkg::C_FIX;
				end
			end
			ddgo_pkg::C_FIX:  state_d = ddgo_pkg::C_RND;
			ddgo_pkg::C_RND:  state_d = ddgo_pkg::C_DONE;
			ddgo_pkg::C_DONE: state_d = ddgo_pkg::C_IDLE;
			default:          state_d = ddgo_pkg::C_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		rsp.done    = (state_q == ddgo_pkg::C_DONE);
		rsp.cos_q15 = cos_q;
		rsp.sin_q15 = sin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddgo_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Rotation datapath: load, one micro-rotation a cycle, sign fix, rounding.
	always_ff @(posedge clk) begin
		case (state_q)
			ddgo_pkg::C_IDLE: begin
				x_q   <= ddgo_pkg::CordicGainQ30;
				y_q   <= '0;
				z_q   <= {fold, 16'h0000};
				i_q   <= '0;
				neg_q <= fold_neg;
			end
			ddgo_pkg::C_ROT: begin
				if (!z_q[31]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_i;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_i;
				end
				i_q <= i_q + 4'd1;
			end
			ddgo_pkg::C_FIX: begin
				if (neg_q) begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
			end
			ddgo_pkg::C_RND: begin
				cos_q <= q30_to_q15(x_q);
				sin_q <= q30_to_q15(y_q);
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/diff_drive_gyro_odometry.sv
// Top level: differential-drive odometry with gyro heading.
//
//  Channel | Signals                       | Word
//  --------+-------------------------------+--------------------------------------------
//  in      | s_tvalid s_tready s_tdata[47:0] | encoder_left, encoder_right, gyro_centideg
//  out     | m_tvalid m_tready m_tdata[79:0] | pos_x_q16, pos_y_q16, heading_centideg
//  config  | cfg_valid cfg_ready cfg_data    | meters_per_tick_q32 (24 bits)
//
// Each word is worked through to its result before the next word is taken; the sixteen
// rotator iterations and five passes through the shared multiplier, with rounding and
// accumulation, lie between acceptance and the result being offered. s_tready is high only
// while the sequencer is idle; while the previous result waits on m_tready the sequencer
// holds in its last step, so input stalls. Reset clears the origin, the position and the
// sequencers, and loads the default scale.
module diff_drive_gyro_odometry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] encoder_left, [31:16] encoder_right, [47:32] gyro_centideg
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] pos_x_q16, [63:32] pos_y_q16, [79:64] heading_centideg
	output logic [79:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	ddgo_pkg::ddgo_state_t state_q, state_d;

	logic               started_q;
	logic [15:0]        last_left_q, last_right_q;
	logic signed [15:0] origin_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic [23:0]        mpt_q;
	logic signed [17:0] sum_q;
	logic signed [16:0] hraw_q;
	logic signed [15:0] h_q;
	logic signed [41:0] p_q;
	logic signed [57:0] prod_q;
	logic signed [25:0] step_q;
	logic               sel_y_q;
	logic               m_tvalid_q;
	logic [79:0]        m_tdata_q;

	logic [15:0]        enc_l, enc_r;
	logic signed [15:0] gyro;
	logic [15:0]        base_l, base_r;
	logic signed [15:0] base_g;
	logic signed [16:0] dl, dr;
	logic signed [16:0] h_norm;

	logic               accept, out_free, out_load;
	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [42:0] mul_p;
	logic signed [15:0] trig;
	logic signed [57:0] rnd;
	logic signed [32:0] acc_sum;
	logic signed [31:0] acc_sel, acc_new;

	ddgo_pkg::ddgo_cordic_req_t cordic_req;
	ddgo_pkg::ddgo_cordic_rsp_t cordic_rsp;

	// Wheel delta with correction for counter wrap.
	function automatic logic signed [16:0] wheel_delta(input logic [15:0] last,
		input logic [15:0] now);
		logic signed [17:0] d;
		d = $signed({2'b00, now}) - $signed({2'b00, last});
		if (now > ddgo_pkg::WrapHi && last < ddgo_pkg::WrapLo) begin
			d = d - 18'sd65536;
		end else if (now < ddgo_pkg::WrapLo && last > ddgo_pkg::WrapHi) begin
			d = d + 18'sd65536;
		end
		return d[16:0];
	endfunction

	// Input word fields; the first frame uses itself as reference.
	assign enc_l  = s_tdata[15:0];
	assign enc_r  = s_tdata[31:16];
	assign gyro   = $signed(s_tdata[47:32]);
	assign base_l = started_q ? last_left_q : enc_l;
	assign base_r = started_q ? last_right_q : enc_r;
	assign base_g = started_q ? origin_q : gyro;
	assign dl     = wheel_delta(base_l, enc_l);
	assign dr     = wheel_delta(base_r, enc_r);

	// Bring the raw heading difference into [-180, 180) degrees.
	always_comb begin
		h_norm = hraw_q;
		if (hraw_q >= ddgo_pkg::HalfTurn + ddgo_pkg::FullTurn) begin
			h_norm = hraw_q - 17'(2 * ddgo_pkg::FullTurn);
		end else if (hraw_q >= ddgo_pkg::HalfTurn) begin
			h_norm = hraw_q - ddgo_pkg::FullTurn;
		end else if (hraw_q < -(ddgo_pkg::HalfTurn + ddgo_pkg::FullTurn)) begin
			h_norm = hraw_q + 17'(2 * ddgo_pkg::FullTurn);
		end else if (hraw_q < -ddgo_pkg::HalfTurn) begin
			h_norm = hraw_q + ddgo_pkg::FullTurn;
		end
	end

	ddgo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cordic_req),
		.rsp    (cordic_rsp)
	);

	// Shared multiplier: distance product, then low and high halves against cos or sin.
	assign trig = sel_y_q ? cordic_rsp.sin_q15 : cordic_rsp.cos_q15;
	always_comb begin
		case (state_q)
			ddgo_pkg::S_MUL_P: begin
				mul_a = $signed({1'b0, mpt_q});
				mul_b = sum_q;
			end
			ddgo_pkg::S_MUL_LO: begin
				mul_a = $signed({4'b0000, p_q[20:0]});
				mul_b = 18'(trig);
			end
			ddgo_pkg::S_MUL_HI: begin
				mul_a = 25'($signed(p_q[41:21]));
				mul_b = 18'(trig);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = 43'(mul_a) * 43'(mul_b);

	// Divide by 2^32 rounding half away from zero.
	assign rnd = prod_q + (prod_q[57] ? 58'sh7FFF_FFFF : 58'sh8000_0000);

	// Saturating accumulate into x or y.
	assign acc_sel = sel_y_q ? acc_y_q : acc_x_q;
	assign acc_sum = 33'(acc_sel) + 33'(step_q);
	always_comb begin
		acc_new = acc_sum[31:0];
		if (acc_sum[32] != acc_sum[31]) begin
			acc_new = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ddgo_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = ddgo_pkg::S_PREP;
				end
			end
			ddgo_pkg::S_PREP:   state_d = ddgo_pkg::S_CSTART;
			ddgo_pkg::S_CSTART: state_d = ddgo_pkg::S_CWAIT;
			ddgo_pkg::S_CWAIT: begin
				if (cordic_rsp.done) begin
					state_d = ddgo_pkg::S_MUL_P;
				end
			end
			ddgo_pkg::S_MUL_P:  state_d = ddgo_pkg::S_MUL_LO;
			ddgo_pkg::S_MUL_LO: state_d = ddgo_pkg::S_MUL_HI;
			ddgo_pkg::S_MUL_HI: state_d = ddgo_pkg::S_ROUND;
			ddgo_pkg::S_ROUND:  state_d = ddgo_pkg::S_ACC;
			ddgo_pkg::S_ACC: begin
				state_d = sel_y_q ? ddgo_pkg::S_DONE : ddgo_pkg::S_MUL_LO;
			end
			ddgo_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ddgo_pkg::S_IDLE;
				end
			end
			default: state_d = ddgo_pkg::S_IDLE;
		endcase
	end

	// Handshake and control outputs.
	always_comb begin
		s_tready         = (state_q == ddgo_pkg::S_IDLE);
		accept           = s_tvalid && s_tready;
		out_free         = !m_tvalid_q || m_tready;
		out_load         = (state_q == ddgo_pkg::S_DONE) && out_free;
		cordic_req.start = (state_q == ddgo_pkg::S_CSTART);
		cordic_req.angle = h_q;
		cfg_ready        = 1'b1;
		m_tvalid         = m_tvalid_q;
		m_tdata          = m_tdata_q;
	end

	// Control state, reference values, position and wheel scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ddgo_pkg::S_IDLE;
			started_q    <= 1'b0;
			last_left_q  <= '0;
			last_right_q <= '0;
			origin_q     <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			mpt_q        <= ddgo_pkg::MptReset;
			m_tvalid_q   <= 1'b0;
			sel_y_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				mpt_q <= cfg_data;
			end
			if (accept) begin
				started_q    <= 1'b1;
				last_left_q  <= enc_l;
				last_right_q <= enc_r;
				origin_q     <= base_g;
			end
			if (state_q == ddgo_pkg::S_PREP) begin
				sel_y_q <= 1'b0;
			end
			if (state_q == ddgo_pkg::S_ACC) begin
				if (sel_y_q) begin
					acc_y_q <= acc_new;
				end else begin
					acc_x_q <= acc_new;
					sel_y_q <= 1'b1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q  <= 18'(dl) + 18'(dr);
			hraw_q <= 17'(gyro) - 17'(base_g);
		end
		if (state_q == ddgo_pkg::S_PREP) begin
			h_q <= h_norm[15:0];
		end
		if (state_q == ddgo_pkg::S_MUL_P) begin
			p_q <= mul_p[41:0];
		end
		if (state_q == ddgo_pkg::S_MUL_LO) begin
			prod_q <= 58'(mul_p);
		end
		if (state_q == ddgo_pkg::S_MUL_HI) begin
			prod_q <= prod_q + (58'(mul_p) <<< 21);
		end
		if (state_q == ddgo_pkg::S_ROUND) begin
			step_q <= rnd[57:32];
		end
		if (out_load) begin
			m_tdata_q <= {h_q, acc_y_q, acc_x_q};
		end
	end

endmodule

FILE: src/ddgo_checker.sv
// Port-level checks for the odometry block, bound to the top level.
module ddgo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	// After a word is taken the block is busy for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is still in work");

	// A new result appears only at the end of a busy period.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result offered without a word in work");

	// A result held back keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Reported heading lies in [-180, 180) degrees.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[79:64]) >= -16'sd18000) &&
			($signed(m_tdata[79:64]) <= 16'sd17999))
		else $error("heading out of range");

endmodule

bind diff_drive_gyro_odometry ddgo_checker u_ddgo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: dv/diff_drive_gyro_odometry_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the gyro-aided odometry block: predicts each pose word and compares.
module diff_drive_gyro_odometry_tb;

	// Encoder wrap window and angle constants, hundredths of a degree.
	localparam longint WrapHigh      = 60000;
	localparam longint WrapLow       = 5000;
	localparam longint WrapSpan      = 65536;
	localparam int     HalfTurnCd    = 18000;
	localparam int     FullTurnCd    = 36000;
	localparam int     QuarterTurnCd = 9000;
	localparam longint RotGainQ30    = 652032874;
	localparam longint PosMax        = 64'sd2147483647;
	localparam longint PosMin        = -64'sd2147483648;
	localparam int     SettleCycles  = 40;

	// Pose word as it leaves the block, lowest field in the lowest bits.
	typedef struct packed {
		logic signed [15:0] heading;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} pose_t;

	// Tracks the robot pose from accepted sensor words and checks each pose word.
	class pose_scoreboard;
		bit          started = 1'b0;
		logic [15:0] last_left = '0;
		logic [15:0] last_right = '0;
		int          gyro_origin = 0;
		int          acc_x = 0;
		int          acc_y = 0;
		logic [23:0] wheel_scale = ddgo_pkg::MptReset;
		pose_t       pose_q[$];
		int          mismatch_count = 0;

		task report(input string msg);
			if (mismatch_count < 50)
				$display("MISMATCH at %0t ns: %s", $time, msg);
			mismatch_count++;
		endtask

		// Arctangent of 2^-i in hundredths of a degree scaled by 2^16.
		function longint atan_step(int i);
			case (i)
				0:       return 294912000;
				1:       return 174096719;
				2:       return 91987925;
				3:       return 46694507;
				4:       return 23437864;
				5:       return 11730358;
				6:       return 5866610;
				7:       return 2933484;
				8:       return 1466765;
				9:       return 733385;
				10:      return 366693;
				11:      return 183346;
				12:      return 91673;
				13:      return 45837;
				14:      return 22918;
				default: return 11459;
			endcase
		endfunction

		// Tick count travelled since the last word, allowing for counter wrap.
		function longint wheel_delta(logic [15:0] last, logic [15:0] now);
			longint a;
			longint p;
			a = now;
			p = last;
			if (a > WrapHigh && p < WrapLow)
				return a - p - WrapSpan;
			if (a < WrapLow && p > WrapHigh)
				return a - p + WrapSpan;
			return a - p;
		endfunction

		function longint to_q15(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > 32767)
				r = 32767;
			else if (r < -32768)
				r = -32768;
			return r;
		endfunction

		// Cosine and sine of a heading by sixteen shift-and-add rotations.
		function void rotate(int hdg, output longint cos_q15, output longint sin_q15);
			longint x;
			longint y;
			longint z;
			longint dx;
			longint dy;
			int     a;
			bit     flip;
			x = RotGainQ30;
			y = 0;
			a = hdg;
			flip = 1'b0;
			// Fold the back half-plane onto the front and negate afterwards.
			if (a > QuarterTurnCd) begin
				a -= HalfTurnCd;
				flip = 1'b1;
			end else if (a < -QuarterTurnCd) begin
				a += HalfTurnCd;
				flip = 1'b1;
			end
			z = longint'(a) * 65536;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_step(i);
				end else begin
					x += dx;
					y -= dy;
					z += atan_step(i);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			cos_q15 = to_q15(x);
			sin_q15 = to_q15(y);
		endfunction

		// Drop 32 fraction bits, rounding half away from zero.
		function longint round_q16(longint p);
			longint m;
			longint q;
			m = (p < 0) ? -p : p;
			q = (m + 64'sd2147483648) >> 32;
			return (p < 0) ? -q : q;
		endfunction

		function int sat32(int a, longint d);
			longint r;
			r = longint'(a) + d;
			if (r > PosMax)
				r = PosMax;
			else if (r < PosMin)
				r = PosMin;
			return int'(r);
		endfunction

		// Advance the pose by one accepted sensor word and queue the pose word.
		function void note_frame(logic [47:0] w);
			logic [15:0]        el;
			logic [15:0]        er;
			logic signed [15:0] g16;
			int                 g;
			int                 h;
			longint             dl;
			longint             dr;
			longint             scale;
			longint             travel;
			longint             c;
			longint             s;
			pose_t              p;
			el = w[15:0];
			er = w[31:16];
			g16 = w[47:32];
			g = g16;
			// The first word after reset sets the origin.
			if (!started) begin
				last_left = el;
				last_right = er;
				gyro_origin = g;
				started = 1'b1;
			end
			dl = wheel_delta(last_left, el);
			dr = wheel_delta(last_right, er);
			h = g - gyro_origin;
			while (h >= HalfTurnCd)
				h -= FullTurnCd;
			while (h < -HalfTurnCd)
				h += FullTurnCd;
			rotate(h, c, s);
			scale = wheel_scale;
			travel = (dl + dr) * scale;
			acc_x = sat32(acc_x, round_q16(travel * c));
			acc_y = sat32(acc_y, round_q16(travel * s));
			last_left = el;
			last_right = er;
			p.pos_x = acc_x;
			p.pos_y = acc_y;
			p.heading = h[15:0];
			pose_q = {pose_q, p};
		endfunction

		// Compare one pose word with the oldest queued pose.
		task check_pose(input logic [79:0] d);
			pose_t e;
			pose_t got;
			got = d;
			if (pose_q.size() == 0) begin
				report($sformatf("pose word %h with none expected", d));
				return;
			end
			e = pose_q.pop_front();
			if (got.pos_x !== e.pos_x)
				report($sformatf("pos_x got %0d expected %0d", got.pos_x, e.pos_x));
			if (got.pos_y !== e.pos_y)
				report($sformatf("pos_y got %0d expected %0d", got.pos_y, e.pos_y));
			if (got.heading !== e.heading)
				report($sformatf("heading got %0d expected %0d", got.heading, e.heading));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [15:0] encoder_left, [31:16] encoder_right, [47:32] gyro_centideg
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [31:0] pos_x_q16, [63:32] pos_y_q16, [79:64] heading_centideg
	logic [79:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data = '0;

	pose_scoreboard board = new;

	int          send_gap_pct = 24;
	int          recv_gap_pct = 86;
	int          hold_request = 0;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	logic [15:0] cur_left = '0;
	logic [15:0] cur_right = '0;
	int          cur_gyro = 0;

	diff_drive_gyro_odometry u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("[diff_drive_gyro_odometry] ERROR");
		$finish;
	end

	// Pose receiver: check each accepted word, then choose the next ready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_pose(m_tdata);
		if (hold_request > 0 && !hold_taken) begin
			hold_left = hold_request;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	function automatic int wrap_heading(int a);
		while (a >= HalfTurnCd)
			a -= FullTurnCd;
		while (a < -HalfTurnCd)
			a += FullTurnCd;
		return a;
	endfunction

	// Offer one sensor word, idling at random first, until it is taken.
	task automatic send_frame(input logic [15:0] el, input logic [15:0] er, input int g);
		logic [47:0] w;
		w = {g[15:0], er, el};
		cur_left = el;
		cur_right = er;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_frame(w);
	endtask

	// Stop offering and wait for every pose word plus the pipeline depth.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pose_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_scale(input logic [23:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.wheel_scale = v;
	endtask

	// Drive straight along a course at full encoder swing, reversing the wheels
	// every other word and turning the heading half round so that travel adds up.
	task automatic sprint(input int course, input int n);
		bit fwd;
		for (int i = 0; i < n; i++) begin
			fwd = (i % 2 == 0);
			send_frame(fwd ? 16'd60000 : 16'd0, fwd ? 16'd60000 : 16'd0,
				wrap_heading(board.gyro_origin + course + (fwd ? 0 : HalfTurnCd)));
		end
	endtask

	// Mostly plausible motion, with wrap-window probes and some noise.
	task automatic wander(input int n);
		int          pick;
		int          g;
		logic [15:0] el;
		logic [15:0] er;
		repeat (n) begin
			pick = $urandom_range(99);
			el = cur_left + 16'($urandom_range(6000)) - 16'd3000;
			er = cur_right + 16'($urandom_range(6000)) - 16'd3000;
			cur_gyro = wrap_heading(cur_gyro + int'($urandom_range(1000)) - 500);
			g = cur_gyro;
			if (pick >= 70 && pick < 85) begin
				el = $urandom_range(1) ? 16'($urandom_range(4999)) : 16'($urandom_range(65535, 60001));
				er = $urandom_range(1) ? 16'($urandom_range(4999)) : 16'($urandom_range(65535, 60001));
			end else if (pick >= 85 && pick < 95) begin
				el = 16'($urandom);
				er = 16'($urandom);
				cur_gyro = int'($urandom_range(FullTurnCd)) - HalfTurnCd;
				g = cur_gyro;
			end else if (pick >= 95) begin
				g = int'($urandom_range(65535)) - 32768;
			end
			send_frame(el, er, g);
		end
	endtask

	// Main sequence.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words; the first one sets the gyro origin at -180 degrees.
		send_frame(16'hFFFF, 16'h0000, -18000);
		send_frame(16'd0, 16'd65535, -9000);     // wrap both ways; exactly a quarter turn
		send_frame(16'd4999, 16'd60001, -8999);  // just past a quarter turn
		send_frame(16'd60001, 16'd4999, -27000); // wraps at window edges; gyro out of range
		send_frame(16'd5000, 16'd60000, -27001); // large jumps just outside the windows
		send_frame(16'd60001, 16'd0, -1);        // heading just under a half turn
		send_frame(16'd0, 16'd60000, 0);         // heading exactly a half turn
		send_frame(16'd1000, 16'd61000, 32767);  // most positive gyro code
		send_frame(16'd2000, 16'd62000, -32768); // most negative gyro code
		send_frame(16'd3000, 16'd63000, 18000);  // top of the gyro range, heading zero
		send_frame(16'd8000, 16'd3000, -13500);
		send_frame(16'd8000, 16'd3000, -13500);  // standing still
		send_frame(16'd9000, 16'd4000, 0);
		send_frame(16'd12000, 16'd9000, -22500);
		send_frame(16'd40000, 16'd35000, -4500);
		send_frame(16'd40000, 16'd35000, -31500);
		send_frame(16'd30000, 16'd45000, -9001);
		send_frame(16'd30000, 16'd45000, -26999);

		// Widest wheel scale: drive both axes into saturation and back out the other way.
		write_scale(24'hFFFFFF);
		sprint(4500, 250);
		send_gap_pct = 86;
		recv_gap_pct = 24;
		sprint(-13500, 450);

		write_scale(24'd0);
		wander(150);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_scale(24'd1);
		wander(100);

		// Random scale, with a long receiver hold-off part way through.
		write_scale(24'($urandom));
		wander(150);
		hold_request = 400;
		wander(150);

		write_scale(ddgo_pkg::MptReset);
		wander(300);

		settle();
		if (board.pose_q.size() != 0)
			board.report($sformatf("%0d pose words never arrived", board.pose_q.size()));
		if (board.mismatch_count == 0)
			$display("[diff_drive_gyro_odometry] OK");
		else
			$display("[diff_drive_gyro_odometry] ERROR");
		$finish;
	end

endmodule
